@@ hdl/mmcd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the min/max column decimator.
package mmcd_pkg;

  localparam int COORD_BITS = 24;
  localparam int COUNT_BITS = 16;
  localparam int SUM_BITS   = COORD_BITS + COUNT_BITS;
  localparam int SCALE_BITS = 24;
  localparam int COL_BITS   = 16;
  localparam int X_FRAC     = 8;
  localparam int SCALE_FRAC = 16;
  localparam int COL_SHIFT  = X_FRAC + SCALE_FRAC;
  localparam int PROD_BITS  = COORD_BITS + SCALE_BITS;
  localparam int RND_BITS   = (PROD_BITS + 1 > COL_SHIFT + COL_BITS) ?
                              PROD_BITS + 1 : COL_SHIFT + COL_BITS;
  localparam int DIV_STEP_BITS = $clog2(SUM_BITS);
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(65536);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
  localparam logic [RND_BITS-1:0]   ROUND_HALF  = RND_BITS'(1) << (COL_SHIFT - 1);
  localparam logic [DIV_STEP_BITS-1:0] DIV_LAST = DIV_STEP_BITS'(SUM_BITS - 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t sample_x;
    coord_t sample_y;
    logic   end_of_curve;
  } sample_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   last_of_run;
    logic   curve_done;
  } point_t;

  // One closed column handed from the front to the back.
  typedef struct packed {
    logic signed [SUM_BITS-1:0] x_sum;
    logic [COUNT_BITS-1:0]      sample_count;
    coord_t                     y_low;
    coord_t                     y_high;
    logic                       parity;
    logic                       run_end;
    logic                       curve_end;
  } col_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ hdl/min_max_column_decimator.sv @@
`timescale 1ns / 1ps
// Top level of the min/max column decimator.
//
// The block reduces a curve of screen-mapped samples (x and y in signed Q16.8)
// to at most two points per screen column. Each sample is placed in column
// round(x * bin_scale), rounded half away from zero; while samples stay in one
// column the block keeps their count, x sum and y extremes. When a sample opens
// a new column, or after a sample that carries end_of_curve, the closed column
// is sent out as its mean x (truncated toward zero) paired with its minimum and
// maximum y, min first on even column ordinals and max first on odd ones, or as
// one point when the two are equal. The front end works on one sample at a time:
// it captures the sample, does the column multiply, then compares and updates
// the open column, stalling while the queue is full; a sample ending the curve
// then hands off the flushed column in a further state. Closed columns wait in a
// two-entry queue for the back end, which pops a column, divides its sum by its
// count in a bit-serial divider and emits its points before it pops the next; a
// burst of short columns stalls the input once the queue is full. The output
// register lets the back end load the next point in the same cycle the current
// beat is taken. bin_scale is written through the cfg port, which is always
// ready, and must only be changed while no sample is in flight.
module min_max_column_decimator
  import mmcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sample_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output point_t                out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SCALE_BITS-1:0] cfg_data
);

  logic [SCALE_BITS-1:0] bin_scale_r;

  logic          q_push;
  logic          q_pop;
  col_rec_t      q_push_rec;
  col_rec_t      q_pop_rec;
  queue_status_t q_status;

  // The single configuration register; writes are never held off.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_scale_r <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      bin_scale_r <= cfg_data;
    end
  end

  // Column mapping and accumulation.
  mmcd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .bin_scale (bin_scale_r),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_rec     (q_push_rec)
  );

  // Closed columns waiting for the divider.
  mmcd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_push_rec),
    .pop      (q_pop),
    .pop_rec  (q_pop_rec),
    .status   (q_status)
  );

  // Mean computation and point emission.
  mmcd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_rec     (q_pop_rec),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // The front end never hands a column to a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("column queue overflow");

  // The back end never takes a column from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("column queue underflow");

  // A sample is worked on in the multiply and update states, so the input holds off right after a beat.
  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken on consecutive cycles");
`endif

endmodule

@@ hdl/mmcd_queue.sv @@
`timescale 1ns / 1ps
// Short register queue of closed column records between front and back.
module mmcd_queue
  import mmcd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  col_rec_t      push_rec,
  input  logic          pop,
  output col_rec_t      pop_rec,
  output queue_status_t status
);

  col_rec_t                entry_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_BITS-1:0]   cnt_r, cnt_nxt;

  function automatic logic [Q_PTR_BITS-1:0] ptr_inc(input logic [Q_PTR_BITS-1:0] p);
    if (p == Q_PTR_BITS'(Q_DEPTH - 1)) begin
      return '0;
    end
    return p + Q_PTR_BITS'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_BITS'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

  assign pop_rec      = entry_r[rd_ptr_r];
  assign status.full  = (cnt_r == Q_CNT_BITS'(Q_DEPTH));
  assign status.empty = (cnt_r == '0);

endmodule

@@ hdl/mmcd_front.sv @@
`timescale 1ns / 1ps
// Front end: takes samples, maps them to columns and accumulates the open column.
module mmcd_front
  import mmcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [SCALE_BITS-1:0] bin_scale,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sample_t               in_data,
  input  queue_status_t         q_status,
  output logic                  q_push,
  output col_rec_t              q_rec
);

  typedef enum logic [3:0] {
    F_IDLE  = 4'b0001,
    F_MUL   = 4'b0010,
    F_UPD   = 4'b0100,
    F_FLUSH = 4'b1000
  } front_state_t;

  front_state_t state_r, state_nxt;

  coord_t                     x_r, y_r;
  logic                       last_r;
  logic [PROD_BITS-1:0]       prod_r;

  logic                       open_r, open_nxt;
  logic [COL_BITS-1:0]        col_r, col_nxt;
  logic [COUNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic signed [SUM_BITS-1:0] sum_r, sum_nxt;
  coord_t                     low_r, low_nxt;
  coord_t                     high_r, high_nxt;
  logic                       par_r, par_nxt;

  logic [COORD_BITS-1:0]      x_mag;
  logic [RND_BITS-1:0]        rnd;
  logic [COL_BITS-1:0]        col_mag;
  logic [COL_BITS-1:0]        col_calc;
  logic                       accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != F_IDLE);

  // Magnitude of x, then round half away from zero and reapply the sign.
  assign x_mag    = x_r[COORD_BITS-1] ? (~x_r + COORD_BITS'(1)) : x_r;
  assign rnd      = RND_BITS'(prod_r) + ROUND_HALF;
  assign col_mag  = rnd[COL_SHIFT +: COL_BITS];
  assign col_calc = x_r[COORD_BITS-1] ? (~col_mag + COL_BITS'(1)) : col_mag;

  always_comb begin
    state_nxt = state_r;
    open_nxt  = open_r;
    col_nxt   = col_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    par_nxt   = par_r;
    q_push    = 1'b0;

    q_rec.x_sum        = sum_r;
    q_rec.sample_count = cnt_r;
    q_rec.y_low        = low_r;
    q_rec.y_high       = high_r;
    q_rec.parity       = par_r;
    q_rec.run_end      = !last_r;
    q_rec.curve_end    = 1'b0;

    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        state_nxt = F_UPD;
      end
      F_UPD: begin
        if (open_r && (col_calc == col_r)) begin
          if (cnt_r < COUNT_MAX) begin
            cnt_nxt = cnt_r + COUNT_BITS'(1);
            sum_nxt = sum_r + SUM_BITS'(x_r);
          end
          if (y_r < low_r) begin
            low_nxt = y_r;
          end
          if (y_r > high_r) begin
            high_nxt = y_r;
          end
          state_nxt = last_r ? F_FLUSH : F_IDLE;
        end else if (!(open_r && q_status.full)) begin
          q_push    = open_r;
          par_nxt   = open_r ? !par_r : 1'b0;
          open_nxt  = 1'b1;
          col_nxt   = col_calc;
          cnt_nxt   = COUNT_BITS'(1);
          sum_nxt   = SUM_BITS'(x_r);
          low_nxt   = y_r;
          high_nxt  = y_r;
          state_nxt = last_r ? F_FLUSH : F_IDLE;
        end
      end
      F_FLUSH: begin
        q_rec.run_end   = 1'b1;
        q_rec.curve_end = 1'b1;
        if (!q_status.full) begin
          q_push    = 1'b1;
          open_nxt  = 1'b0;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      open_r  <= 1'b0;
      col_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
      low_r   <= '0;
      high_r  <= '0;
      par_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      open_r  <= open_nxt;
      col_r   <= col_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      par_r   <= par_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= in_data.sample_x;
      y_r    <= in_data.sample_y;
      last_r <= in_data.end_of_curve;
    end
    if (state_r == F_MUL) begin
      prod_r <= PROD_BITS'(x_mag) * PROD_BITS'(bin_scale);
    end
  end

endmodule

@@ hdl/mmcd_back.sv @@
`timescale 1ns / 1ps
// Back end: divides each column sum by its count and emits the min/max points.
module mmcd_back
  import mmcd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  queue_status_t q_status,
  input  col_rec_t      q_rec,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output point_t        out_data
);

  typedef enum logic [3:0] {
    B_IDLE   = 4'b0001,
    B_DIV    = 4'b0010,
    B_FIRST  = 4'b0100,
    B_SECOND = 4'b1000
  } back_state_t;

  back_state_t state_r, state_nxt;

  col_rec_t                  rec_r;
  logic                      neg_r;
  logic [SUM_BITS-1:0]       quo_r, quo_nxt;
  logic [COUNT_BITS-1:0]     rem_r, rem_nxt;
  logic [DIV_STEP_BITS-1:0]  step_r, step_nxt;

  logic [SUM_BITS-1:0]       dvd_mag;
  logic [COUNT_BITS:0]       rem_sh;
  logic [COUNT_BITS:0]       diff;
  logic                      fits;
  logic [SUM_BITS-1:0]       mean_full;
  logic                      single;

  logic                      out_valid_r, out_valid_nxt;
  point_t                    out_data_r, out_data_nxt;
  logic                      out_free;
  logic                      load;

  assign out_free = !out_valid_r || !out_stall;
  assign single   = (rec_r.y_low == rec_r.y_high);

  // Restoring division, one quotient bit per cycle.
  assign dvd_mag   = q_rec.x_sum[SUM_BITS-1] ? (~q_rec.x_sum + SUM_BITS'(1)) : q_rec.x_sum;
  assign rem_sh    = {rem_r, quo_r[SUM_BITS-1]};
  assign diff      = rem_sh - {1'b0, rec_r.sample_count};
  assign fits      = !diff[COUNT_BITS];
  assign mean_full = neg_r ? (~quo_r + SUM_BITS'(1)) : quo_r;

  always_comb begin
    state_nxt    = state_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    step_nxt     = step_r;
    q_pop        = 1'b0;
    load         = 1'b0;
    out_data_nxt = out_data_r;

    unique case (state_r)
      B_IDLE: begin
        if (!q_status.empty) begin
          q_pop     = 1'b1;
          quo_nxt   = dvd_mag;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        rem_nxt  = fits ? diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
        quo_nxt  = {quo_r[SUM_BITS-2:0], fits};
        step_nxt = step_r + DIV_STEP_BITS'(1);
        if (step_r == DIV_LAST) begin
          state_nxt = B_FIRST;
        end
      end
      B_FIRST: begin
        if (out_free) begin
          load                     = 1'b1;
          out_data_nxt.point_x     = mean_full[COORD_BITS-1:0];
          out_data_nxt.point_y     = (single || !rec_r.parity) ? rec_r.y_low : rec_r.y_high;
          out_data_nxt.last_of_run = single && rec_r.run_end;
          out_data_nxt.curve_done  = single && rec_r.curve_end;
          state_nxt                = single ? B_IDLE : B_SECOND;
        end
      end
      B_SECOND: begin
        if (out_free) begin
          load                     = 1'b1;
          out_data_nxt.point_x     = mean_full[COORD_BITS-1:0];
          out_data_nxt.point_y     = rec_r.parity ? rec_r.y_low : rec_r.y_high;
          out_data_nxt.last_of_run = rec_r.run_end;
          out_data_nxt.curve_done  = rec_r.curve_end;
          state_nxt                = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
    if (q_pop) begin
      rec_r <= q_rec;
      neg_r <= q_rec.x_sum[SUM_BITS-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
